[rtl/rmad_pkg.sv]
// Shared types and constants for the running median / absolute deviation block.
// No dependencies; imported by rmad_cell, rmad_chain and the top level.
`default_nettype none

package rmad_pkg;

  // fixed field widths
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned OFF_W        = 32;
  localparam int unsigned OFF_TOT_W    = 42;
  localparam int unsigned COST_W       = 45;
  localparam int unsigned CNT_OUT_W    = 11;
  localparam int unsigned CAPACITY_DEF = 1024;

  // offset total saturation limits
  localparam logic signed [OFF_TOT_W-1:0] OFF_TOT_MAX = {1'b0, {(OFF_TOT_W-1){1'b1}}};
  localparam logic signed [OFF_TOT_W-1:0] OFF_TOT_MIN = {1'b1, {(OFF_TOT_W-1){1'b0}}};

  // insert request broadcast along the cell row
  typedef struct packed {
    logic                    en;
    logic signed [VAL_W-1:0] value;
  } ins_req_t;

  // values read around the median position before an insert
  typedef struct packed {
    logic signed [VAL_W-1:0] below;  // entry k-1
    logic signed [VAL_W-1:0] at;     // entry k
  } tap_t;

  // control sequencer, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

`default_nettype wire

[rtl/rmad_cell.sv]
// One entry of the sorted insertion row: holds a value, shifts right on insert.
// Depends on rmad_pkg.
`default_nettype none

module rmad_cell
  import rmad_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire ins_req_t                req_i,
  input  wire logic                    occ_i,      // entry holds a stored value
  input  wire logic signed [VAL_W-1:0] left_val_i,
  input  wire logic                    left_gt_i,  // left neighbor moves right too
  output logic signed [VAL_W-1:0]      val_o,
  output logic                         gt_o
);

  logic signed [VAL_W-1:0] data_q, data_d;

  // empty entries count as larger than anything
  assign gt_o  = !occ_i || (data_q > req_i.value);
  assign val_o = data_q;

  // take the new value at the insert point, the neighbor's value above it
  always_comb begin
    data_d = data_q;
    if (req_i.en && gt_o) begin
      data_d = left_gt_i ? left_val_i : req_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

[rtl/rmad_chain.sv]
// Row of rmad_cell entries kept in ascending order, with taps at the median position.
// Depends on rmad_pkg and rmad_cell.
`default_nettype none

module rmad_chain
  import rmad_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned CNTW    = $clog2(CAPACITY + 1)
) (
  input  wire logic            clk_i,
  input  wire ins_req_t        req_i,
  input  wire logic [CNTW-1:0] count_i,
  output tap_t                 tap_o
);

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  logic                    sel_at   [CAPACITY];
  logic                    sel_blw  [CAPACITY];
  logic [CNTW-1:0]         half_cnt;

  assign half_cnt = count_i >> 1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNTW-1:0] IDX    = CNTW'(i);
    localparam logic [CNTW-1:0] IDX_P1 = CNTW'(i + 1);

    logic signed [VAL_W-1:0] left_val;
    logic                    left_gt;
    logic                    occ;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    assign occ        = count_i > IDX;
    assign sel_at[i]  = half_cnt == IDX;
    assign sel_blw[i] = half_cnt == IDX_P1;

    rmad_cell u_cell (
      .clk_i      (clk_i),
      .req_i      (req_i),
      .occ_i      (occ),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // one-hot tap buses: entries k and k-1, k = count / 2
  always_comb begin
    tap_o.at    = '0;
    tap_o.below = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      tap_o.at    = tap_o.at    | (sel_at[j]  ? cell_val[j] : '0);
      tap_o.below = tap_o.below | (sel_blw[j] ? cell_val[j] : '0);
    end
  end

endmodule

`default_nettype wire

[rtl/running_median_abs_deviation_top.sv]
// Running lower median and sum of absolute deviations, top level.
// Depends on rmad_pkg and rmad_chain (row of rmad_cell entries).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries value_i and offset_i. Each
//   beat inserts value_i into a sorted row of CAPACITY cells and adds offset_i
//   to a saturating 42-bit offset total. When the row is full the value is
//   dropped and full_res_o is set in that beat's result.
//   Output channel (out_valid_o / out_ready_i) returns one beat per input beat:
//   median_o, min_cost_o, full_res_o and count_o, all after the insert.
//   The insert shifts the cell row in the accept cycle, the half sums and
//   median settle in the next one, and the result is loaded into the output
//   register from the finish state; no beat is taken during the sum update,
//   and the next beat is taken as the result loads.
//   A result waiting in the output register does not block the next beat;
//   if the receiver stalls, the block holds the following finished result
//   internally and stops taking input until the output register frees up.
//   Reset clears the count, sums, offset total and output valid; no clearing
//   pass is needed, cell contents past the count are never used.
`default_nettype none

module running_median_abs_deviation_top
  import rmad_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic signed [OFF_W-1:0]  offset_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [VAL_W-1:0]       median_o,
  output logic signed [COST_W-1:0]      min_cost_o,
  output logic                          full_res_o,
  output logic [CNT_OUT_W-1:0]          count_o
);

  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned SUMW = VAL_W + $clog2(CAPACITY) + 1;
  localparam int unsigned CW   = (SUMW + 2 > COST_W) ? SUMW + 2 : COST_W;
  localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

  state_e state_q, state_d;

  logic [CNTW-1:0]             count_q;
  logic signed [SUMW-1:0]      lower_q, total_q;
  logic signed [VAL_W-1:0]     med_q;
  logic signed [OFF_TOT_W-1:0] offtot_q;
  logic                        odd_q;

  // captured at accept
  logic signed [VAL_W-1:0]     v_q;
  logic signed [OFF_W-1:0]     off_q;
  tap_t                        tap_q;
  logic                        full_q, n_zero_q, n_one_q, n_even_q;

  // output register
  logic                        out_valid_q;
  logic signed [VAL_W-1:0]     median_q;
  logic signed [COST_W-1:0]    cost_q;
  logic                        full_out_q;
  logic [CNT_OUT_W-1:0]        count_out_q;

  logic     out_free, in_acc, full_now;
  ins_req_t req;
  tap_t     tap;

  // count zero-extended so the output width can be cut from it
  logic [CNTW+CNT_OUT_W-1:0] count_ext;

  assign count_ext  = {{CNT_OUT_W{1'b0}}, count_q};

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full_now   = count_q == CAP_CNT;

  assign req.en    = in_acc && !full_now;
  assign req.value = value_i;

  rmad_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i   (clk_i),
    .req_i   (req),
    .count_i (count_q),
    .tap_o   (tap)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SUM;
      ST_SUM:  state_d = ST_FIN;
      ST_FIN:  begin
        if (out_free) state_d = in_acc ? ST_SUM : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // median and half-sum update from entries k-1, k of the old row
  logic                    le_k;
  logic signed [VAL_W-1:0] lo_min, med_new;
  logic signed [SUMW-1:0]  v_ext, at_ext, lower_add;
  logic signed [OFF_TOT_W:0] off_sum;
  logic signed [OFF_TOT_W-1:0] offtot_new;

  always_comb begin
    le_k      = n_zero_q || (tap_q.at > v_q);
    lo_min    = (v_q < tap_q.at) ? v_q : tap_q.at;
    if (n_zero_q) begin
      med_new = v_q;
    end else if (n_one_q) begin
      med_new = lo_min;
    end else begin
      med_new = (tap_q.below > lo_min) ? tap_q.below : lo_min;
    end
    v_ext     = {{(SUMW-VAL_W){v_q[VAL_W-1]}}, v_q};
    at_ext    = {{(SUMW-VAL_W){tap_q.at[VAL_W-1]}}, tap_q.at};
    if (n_even_q) begin
      lower_add = le_k ? v_ext : at_ext;
    end else begin
      lower_add = le_k ? (v_ext - at_ext) : '0;
    end
    // saturating offset total
    off_sum = {offtot_q[OFF_TOT_W-1], offtot_q}
            + {{(OFF_TOT_W+1-OFF_W){off_q[OFF_W-1]}}, off_q};
    if (off_sum[OFF_TOT_W] != off_sum[OFF_TOT_W-1]) begin
      offtot_new = off_sum[OFF_TOT_W] ? OFF_TOT_MIN : OFF_TOT_MAX;
    end else begin
      offtot_new = off_sum[OFF_TOT_W-1:0];
    end
  end

  // cost = total - 2*lower + (odd count ? median : 0) + offset total
  logic signed [CW-1:0] cost_w;

  always_comb begin
    cost_w = {{(CW-SUMW){total_q[SUMW-1]}}, total_q}
           - ({{(CW-SUMW){lower_q[SUMW-1]}}, lower_q} <<< 1)
           + (odd_q ? {{(CW-VAL_W){med_q[VAL_W-1]}}, med_q} : '0)
           + {{(CW-OFF_TOT_W){offtot_q[OFF_TOT_W-1]}}, offtot_q};
  end

  // control state and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lower_q     <= '0;
      total_q     <= '0;
      med_q       <= '0;
      offtot_q    <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req.en) begin
        count_q <= count_q + CNTW'(1);
      end
      if (state_q == ST_SUM) begin
        offtot_q <= offtot_new;
        odd_q    <= count_q[0];
        if (!full_q) begin
          med_q   <= med_new;
          lower_q <= lower_q + lower_add;
          total_q <= total_q + v_ext;
        end
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // beat capture and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q      <= value_i;
      off_q    <= offset_i;
      tap_q    <= tap;
      full_q   <= full_now;
      n_zero_q <= count_q == '0;
      n_one_q  <= count_q == CNTW'(1);
      n_even_q <= !count_q[0];
    end
    if ((state_q == ST_FIN) && out_free) begin
      median_q    <= med_q;
      cost_q      <= cost_w[COST_W-1:0];
      full_out_q  <= full_q;
      count_out_q <= count_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;
  assign min_cost_o  = cost_q;
  assign full_res_o  = full_out_q;
  assign count_o     = count_out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT) else $error("stored count beyond capacity");

  a_no_take_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q != ST_SUM) else $error("input taken during sum update");

  a_accept_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SUM) else $error("accepted beat did not start update");

  a_full_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full_now) |=> count_q == $past(count_q))
    else $error("count moved on a dropped value");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free) |=> out_valid_q)
    else $error("finished result not loaded");

endmodule

`default_nettype wire

[tb/tb_running_median_abs_deviation_top.sv]
// Self-checking testbench for running_median_abs_deviation_top.
// Drives value/offset beats, predicts median and deviation cost with a sorted
// queue model kept in the testbench. Depends on rmad_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_running_median_abs_deviation_top
  import rmad_pkg::*;
();

  localparam int unsigned CAPACITY    = CAPACITY_DEF;
  localparam int          DIR_N       = 20;
  localparam int          RAND_MIN    = 1200;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 20;

  // one result beat
  typedef struct packed {
    logic signed [VAL_W-1:0]  median;
    logic signed [COST_W-1:0] min_cost;
    logic                     full_res;
    logic [CNT_OUT_W-1:0]     count;
  } median_result_t;

  // directed stimulus row, expected result used only when typed_exp is set
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [OFF_W-1:0] offset;
    logic                    typed_exp;
    median_result_t          result;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // first beat: extremes, single value is its own median
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1,
      '{32'sh7FFF_FFFF, 45'sd2147483647, 1'b0, 11'd1}},
    // two values: lower median is the minimum, offsets cancel to -1
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1,
      '{32'sh8000_0000, 45'sd4294967294, 1'b0, 11'd2}},
    '{32'sd0, 32'sd0, 1'b1, '{32'sd0, 45'sd4294967294, 1'b0, 11'd3}},
    '{32'sd0, 32'sd1, 1'b1, '{32'sd0, 45'sd4294967295, 1'b0, 11'd4}},
    // duplicates and mixed offsets
    '{32'sd5, 32'sd0, 1'b0, '0},
    '{32'sd5, -32'sd1, 1'b0, '0},
    '{32'sd5, 32'sh7FFF_FFFF, 1'b0, '0},
    '{-32'sd1, 32'sh8000_0000, 1'b0, '0},
    '{32'sd1, 32'sh5555_5555, 1'b0, '0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, '0},
    '{32'sh8000_0001, -32'sd2, 1'b0, '0},
    '{32'sh7FFF_FFFE, 32'sd2, 1'b0, '0},
    '{-32'sd1, -32'sd1, 1'b0, '0},
    '{32'sd0, 32'sh0000_FFFF, 1'b0, '0},
    '{32'sh0000_FFFF, 32'shFFFF_0000, 1'b0, '0},
    '{32'shFFFF_0000, 32'sd0, 1'b0, '0},
    '{32'sd2, 32'sh1234_5678, 1'b0, '0},
    '{-32'sd2, 32'shEDCB_A988, 1'b0, '0},
    '{32'sh7FFF_FFFF, 32'sd0, 1'b0, '0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [VAL_W-1:0]   value_i;
  logic signed [OFF_W-1:0]   offset_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [VAL_W-1:0]   median_o;
  logic signed [COST_W-1:0]  min_cost_o;
  logic                      full_res_o;
  logic [CNT_OUT_W-1:0]      count_o;

  // predictor state
  logic signed [VAL_W-1:0]   sorted_vals [$];
  longint                    offset_total;
  bit                        sat_lo_seen;
  bit                        sat_hi_seen;
  median_result_t            pending_results [$];

  // run control
  int                        mismatch_count;
  int                        results_seen;
  int                        send_idle_pct;
  int                        stall_pct;
  int                        hold_req;       // hold-offs requested so far
  logic signed [VAL_W-1:0]   cluster_center;

  running_median_abs_deviation_top #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .offset_i    (offset_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_o    (median_o),
    .min_cost_o  (min_cost_o),
    .full_res_o  (full_res_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // insert into the sorted set, update the saturating offset total, and
  // compute median and deviation cost after the insert
  function automatic void apply_insert(input logic signed [VAL_W-1:0] v,
                                       input logic signed [OFF_W-1:0] off,
                                       output median_result_t res);
    int     pos;
    int     n;
    int     lo_n;
    int     hi_n;
    longint lo_sum;
    longint hi_sum;
    longint med;
    longint cost;
    longint next_total;

    pos = 0;
    lo_sum = 0;
    hi_sum = 0;
    med = 0;
    cost = 0;
    res = '0;
    if (sorted_vals.size() >= CAPACITY) begin
      res.full_res = 1'b1;
    end else begin
      // equal values go after the stored ones
      while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
      sorted_vals.insert(pos, v);
    end

    next_total = offset_total + longint'(off);
    if (next_total > longint'(OFF_TOT_MAX)) begin
      next_total = longint'(OFF_TOT_MAX);
      sat_hi_seen = 1'b1;
    end
    if (next_total < longint'(OFF_TOT_MIN)) begin
      next_total = longint'(OFF_TOT_MIN);
      sat_lo_seen = 1'b1;
    end
    offset_total = next_total;

    n = sorted_vals.size();
    if (n > 0) begin
      lo_n = (n + 1) / 2;
      hi_n = n - lo_n;
      for (int i = 0; i < n; i++) begin
        if (i < lo_n) lo_sum += sorted_vals[i];
        else          hi_sum += sorted_vals[i];
      end
      med = sorted_vals[lo_n-1];
      cost = (hi_sum - med * hi_n) + (med * lo_n - lo_sum);
    end
    cost += offset_total;

    res.median   = med[VAL_W-1:0];
    res.min_cost = cost[COST_W-1:0];
    res.count    = n[CNT_OUT_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(16) - 8;   // dense duplicates
      6: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default:    return cluster_center + ($urandom_range(64) - 32);
    endcase
  endfunction

  // steer the offset total into the low limit first, then push it back up
  function automatic logic signed [OFF_W-1:0] pick_offset();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!sat_lo_seen && roll < 97) return 32'sh8000_0000;
    if (sat_lo_seen && !sat_hi_seen && roll < 85) return 32'sh7FFF_FFFF;
    case ($urandom_range(3))
      0, 1:    return $urandom;
      2:       return $urandom_range(200) - 100;
      default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // offer one beat, with random idle cycles first; predict on accept
  task automatic send_beat(input logic signed [VAL_W-1:0] v,
                           input logic signed [OFF_W-1:0] off,
                           input logic typed_exp,
                           input median_result_t typed_res);
    median_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      offset_i   <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    offset_i   <= off;
    do @(posedge clk_i); while (!in_ready_o);
    apply_insert(v, off, pred);
    if (typed_exp) pred = typed_res;
    pending_results.push_back(pred);
  endtask

  // receiver ready, with a long hold-off on request
  initial begin : drive_ready
    int holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        holds_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each output beat against the oldest prediction
  always @(posedge clk_i) begin : check_results
    median_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: median %0d cost %0d count %0d",
                                  median_o, min_cost_o, count_o));
      end else begin
        want = pending_results.pop_front();
        if (median_o !== want.median)
          report_mismatch($sformatf("result %0d median: got %0d expected %0d",
                                    results_seen, median_o, want.median));
        if (min_cost_o !== want.min_cost)
          report_mismatch($sformatf("result %0d min_cost: got %0d expected %0d",
                                    results_seen, min_cost_o, want.min_cost));
        if (full_res_o !== want.full_res)
          report_mismatch($sformatf("result %0d full_res: got %0b expected %0b",
                                    results_seen, full_res_o, want.full_res));
        if (count_o !== want.count)
          report_mismatch($sformatf("result %0d count: got %0d expected %0d",
                                    results_seen, count_o, want.count));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int seg;
    int seg_len;
    int rand_sent;

    in_valid_i     = 1'b0;
    value_i        = '0;
    offset_i       = '0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 0;
    mismatch_count = 0;
    results_seen   = 0;
    offset_total   = 0;
    sat_lo_seen    = 1'b0;
    sat_hi_seen    = 1'b0;
    cluster_center = '0;
    rand_sent      = 0;
    seg            = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].value, DIR_ROWS[i].offset, DIR_ROWS[i].typed_exp,
                DIR_ROWS[i].result);

    // random segments, cycling through idle/stall mixes; the store fills and
    // the offset total clips at its low limit on the way
    while (rand_sent < RAND_MIN) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (seg == 4 || seg == 12) hold_req++;
      cluster_center = $urandom;
      seg_len = $urandom_range(200, 60);
      for (int k = 0; k < seg_len && rand_sent < RAND_MIN; k++) begin
        send_beat(pick_value(), pick_offset(), 1'b0, '0);
        rand_sent++;
      end
      seg++;
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[running_median_abs_deviation_top.f]
rtl/rmad_pkg.sv
rtl/rmad_cell.sv
rtl/rmad_chain.sv
rtl/running_median_abs_deviation_top.sv
tb/tb_running_median_abs_deviation_top.sv
